// ----- hw/rtl/sle_pkg.sv -----
// Package for the sequential list engine: sizes, operation and status codes,
// request, response and cell control types. No dependencies.
package sle_pkg;

   localparam int CAPACITY = 128;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOCATE = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [7:0]         position;
      logic signed [31:0] value;
   } sle_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] found_position;
      logic [7:0] list_length;
   } sle_rsp_type;

   typedef struct packed {
      logic               ins;
      logic               del;
      logic               rot;
      logic [IDX_W-1:0]   pos;
      logic signed [31:0] value;
   } sle_cell_ctl_type;

endpackage

// ----- hw/rtl/sequential_list_engine.sv -----
// Top level of the sequential list engine: request control and length counter.
// Depends on sle_pkg and sle_chain.
//
// The list lives in a ring of CAPACITY cells, one entry per cell. A request is
// taken when start is high and busy is low; exactly one response follows as a
// one-cycle rsp_valid strobe, which the receiver cannot hold off. Insert,
// delete and rejected requests answer via the execute state and the registered
// response, since every cell shifts in the same cycle. Locate rotates the whole
// ring once past the head cell, one entry per cycle, and answers after the last
// rotation step. A new request can be taken in the cycle the response is shown.
module sequential_list_engine
   import sle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  sle_req_type req_data,
   output logic        rsp_valid,
   output sle_rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sle_rsp_type        rsp_ff, rsp_in;
   sle_req_type        req_ff;
   sle_cell_ctl_type   ctl;
   logic signed [31:0] head;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   count_ext;

   assign pos_ext   = CMP_W'(req_ff.position);
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      ctl.pos      = IDX_W'(pos_ext - CMP_W'(1));
      ctl.value    = req_ff.value;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in              = S_IDLE;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = ST_DONE;
            rsp_in.found_position = '0;
            unique case (req_ff.operation)
               OP_INSERT: begin
                  if (pos_ext == '0 || pos_ext > count_ext + CMP_W'(1)) begin
                     rsp_in.status = ST_RANGE;
                  end else if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     ctl.ins  = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_DELETE: begin
                  if (pos_ext == '0 || pos_ext > count_ext) begin
                     rsp_in.status = ST_RANGE;
                  end else begin
                     ctl.del  = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               OP_LOCATE: begin
                  state_in     = S_SCAN;
                  rsp_valid_in = 1'b0;
                  step_in      = '0;
                  found_in     = '0;
               end
               default: begin
               end
            endcase
            rsp_in.list_length = 8'(count_in);
         end
         S_SCAN: begin
            ctl.rot = 1'b1;
            if (found_ff == '0 && CNT_W'(step_ff) < count_ff && head == req_ff.value) begin
               found_in = CNT_W'(step_ff) + CNT_W'(1);
            end
            step_in = step_ff + IDX_W'(1);
            if (step_ff == IDX_W'(CAPACITY - 1)) begin
               state_in              = S_IDLE;
               rsp_valid_in          = 1'b1;
               rsp_in.status         = ST_DONE;
               rsp_in.found_position = 8'(found_in);
               rsp_in.list_length    = 8'(count_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_data;
      end
   end

   sle_chain u_chain (
      .clock (clock),
      .ctl   (ctl),
      .head  (head)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/sle_cell.sv -----
// One list cell: holds one entry, loads a neighbor or the inserted value.
// Depends on sle_pkg.
module sle_cell
   import sle_pkg::*;
(
   input  logic               clock,
   input  sle_cell_ctl_type   ctl,
   input  logic [IDX_W-1:0]   cell_index,
   input  logic signed [31:0] left_data,
   input  logic signed [31:0] right_data,
   output logic signed [31:0] data
);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (ctl.ins) begin
         if (cell_index == ctl.pos) begin
            data_in = ctl.value;
         end else if (cell_index > ctl.pos) begin
            data_in = left_data;
         end
      end else if (ctl.del) begin
         if (cell_index >= ctl.pos) begin
            data_in = right_data;
         end
      end else if (ctl.rot) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- hw/rtl/sle_chain.sv -----
// Ring of list cells; cell 0 is the head seen by the controller.
// Depends on sle_pkg and sle_cell.
module sle_chain
   import sle_pkg::*;
(
   input  logic               clock,
   input  sle_cell_ctl_type   ctl,
   output logic signed [31:0] head
);

   logic signed [31:0] cell_data [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sle_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_index (IDX_W'(i)),
         .left_data  ((i == 0) ? 32'sd0 : cell_data[(i == 0) ? 0 : i - 1]),
         .right_data (cell_data[(i + 1) % CAPACITY]),
         .data       (cell_data[i])
      );
   end

   assign head = cell_data[0];

endmodule

// ----- hw/rtl/sle_checker.sv -----
// Port-level checks for the sequential list engine, bound to the top level.
// Depends on sle_pkg and sequential_list_engine.
module sle_checker
   import sle_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input sle_req_type req_data,
   input logic        rsp_valid,
   input sle_rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   a_reject_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |-> rsp_data.found_position == 8'd0)
      else $error("rejected request reports a found position");

endmodule

bind sequential_list_engine sle_checker u_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for sequential_list_engine: drives list requests and checks
// every response against an in-bench model of the list store and its length.
// Depends on sle_pkg and the sequential_list_engine RTL.
module tb_top;
   import sle_pkg::*;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam int         PHASE_ITEMS    = 230;
   localparam int         SETTLE_CYCLES  = CAPACITY + 8;
   localparam int         WATCHDOG_LIMIT = 20 * (CAPACITY + 2);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   sle_req_type req_data = '0;
   logic        busy;
   logic        rsp_valid;
   sle_rsp_type rsp_data;

   sle_req_type        pending_reqs[$];
   sle_rsp_type        expected_rsps[$];
   logic signed [31:0] list_model[CAPACITY];
   int                 list_len = 0;
   logic signed [31:0] value_pool[16];
   int                 gen_len = 0;
   int                 gen_items = 0;
   int                 send_idle_pct = 0;
   int                 fail_count = 0;
   int                 accepted_count = 0;
   int                 full_count = 0;
   int                 range_count = 0;
   int                 locate_hits = 0;
   int                 stalled_cycles = 0;

   sequential_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic sle_rsp_type apply_list_op(sle_req_type r);
      sle_rsp_type rsp;
      int p;
      int j;
      rsp = '0;
      p = r.position;
      case (r.operation)
         OP_INSERT: begin
            if (p < 1 || p > list_len + 1) begin
               rsp.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               rsp.status = ST_FULL;
            end else begin
               for (j = list_len; j >= p; j--) list_model[j] = list_model[j - 1];
               list_model[p - 1] = r.value;
               list_len++;
            end
         end
         OP_DELETE: begin
            if (p < 1 || p > list_len) begin
               rsp.status = ST_RANGE;
            end else begin
               for (j = p; j < list_len; j++) list_model[j - 1] = list_model[j];
               list_len--;
            end
         end
         OP_LOCATE: begin
            for (j = 0; j < list_len; j++)
               if (rsp.found_position == 8'd0 && list_model[j] == r.value)
                  rsp.found_position = 8'(j + 1);
         end
         default: ;
      endcase
      rsp.list_length = 8'(list_len);
      return rsp;
   endfunction

   // driver: hold a request until busy is low, then advance to the next one
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            sle_rsp_type rsp;
            rsp = apply_list_op(req_data);
            expected_rsps.push_back(rsp);
            accepted_count++;
            if (rsp.status == ST_FULL) full_count++;
            if (rsp.status == ST_RANGE) range_count++;
            if (rsp.found_position != 8'd0) locate_hits++;
         end
         if (!start || !busy) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               start    <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: one response per strobe, compared with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: status %0d found %0d length %0d",
                   rsp_data.status, rsp_data.found_position, rsp_data.list_length);
            fail_count++;
         end else begin
            sle_rsp_type exp_rsp;
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.found_position !== exp_rsp.found_position) begin
               $error("found_position: expected %0d, got %0d",
                      exp_rsp.found_position, rsp_data.found_position);
               fail_count++;
            end
            if (rsp_data.list_length !== exp_rsp.list_length) begin
               $error("list_length: expected %0d, got %0d",
                      exp_rsp.list_length, rsp_data.list_length);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   task automatic queue_req(input logic [1:0] op, input int pos,
                            input logic signed [31:0] val);
      sle_req_type r;
      r.operation = op;
      r.position  = 8'(pos);
      r.value     = val;
      pending_reqs.push_back(r);
      gen_items++;
      if (op == OP_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
         gen_len++;
      else if (op == OP_DELETE && pos >= 1 && pos <= gen_len)
         gen_len--;
   endtask

   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(3) == 0) return $urandom;
      return value_pool[$urandom_range(15)];
   endfunction

   task automatic add_fill();
      while (gen_len < CAPACITY) begin
         if ($urandom_range(9) < 2) queue_req(OP_LOCATE, $urandom_range(255), pick_value());
         else queue_req(OP_INSERT, $urandom_range(gen_len + 1, 1), pick_value());
      end
      repeat ($urandom_range(3, 1))
         queue_req(OP_INSERT, $urandom_range(gen_len + 1, 1), pick_value());
      queue_req(OP_INSERT, gen_len + 2, pick_value());
      queue_req(OP_LOCATE, 0, pick_value());
   endtask

   task automatic add_drain();
      while (gen_len > 0) begin
         if ($urandom_range(9) < 2) queue_req(OP_LOCATE, $urandom_range(255), pick_value());
         else queue_req(OP_DELETE, $urandom_range(gen_len, 1), pick_value());
      end
      queue_req(OP_DELETE, 1, pick_value());
   endtask

   task automatic add_mixed();
      int r;
      repeat (30) begin
         r = $urandom_range(99);
         if (r < 40 && gen_len < CAPACITY)
            queue_req(OP_INSERT, $urandom_range(gen_len + 1, 1), pick_value());
         else if (r < 70 && gen_len > 0)
            queue_req(OP_DELETE, $urandom_range(gen_len, 1), pick_value());
         else if (r < 95)
            queue_req(OP_LOCATE, $urandom_range(255), pick_value());
         else
            queue_req(2'($urandom_range(3)), $urandom_range(255), $urandom);
      end
   endtask

   task automatic add_noise();
      repeat (10) queue_req(2'($urandom_range(3)), $urandom_range(255), $urandom);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
   endtask

   initial begin
      int phase_start;
      int seg;
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = 32'sd0;
      value_pool[3] = -32'sd1;
      for (int k = 4; k < 16; k++) value_pool[k] = $urandom;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_req(OP_INSERT, 0, 32'sd5);
      queue_req(OP_INSERT, 2, 32'sd5);
      queue_req(OP_DELETE, 1, 32'sd0);
      queue_req(OP_LOCATE, 0, 32'sd0);
      queue_req(OP_UNUSED, 255, -32'sd1);
      queue_req(OP_INSERT, 1, 32'sh8000_0000);
      queue_req(OP_INSERT, 2, 32'sh7fff_ffff);
      queue_req(OP_INSERT, 1, -32'sd1);
      queue_req(OP_INSERT, 4, 32'sd0);
      queue_req(OP_INSERT, 6, 32'sd9);
      queue_req(OP_INSERT, 255, 32'sd9);
      queue_req(OP_INSERT, 2, 32'sh7fff_ffff);
      queue_req(OP_LOCATE, 255, 32'sh7fff_ffff);
      queue_req(OP_LOCATE, 1, 32'sh8000_0000);
      queue_req(OP_LOCATE, 0, 32'sd0);
      queue_req(OP_LOCATE, 0, 32'sd1234);
      queue_req(OP_UNUSED, 0, 32'sd0);
      queue_req(OP_DELETE, 255, 32'sd0);
      queue_req(OP_DELETE, 0, 32'sd0);
      queue_req(OP_DELETE, 6, 32'sd0);
      queue_req(OP_DELETE, 5, 32'sd0);
      queue_req(OP_DELETE, 1, 32'sd0);
      queue_req(OP_LOCATE, 0, -32'sd1);
      queue_req(OP_LOCATE, 0, 32'sh7fff_ffff);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       send_idle_pct = 53;
            2:       send_idle_pct = 15;
            default: send_idle_pct = 0;
         endcase
         phase_start = gen_items;
         if (phase % 2 == 0) add_fill();
         while (gen_items - phase_start < PHASE_ITEMS) begin
            seg = $urandom_range(9);
            if (seg < 2) add_fill();
            else if (seg < 4) add_drain();
            else if (seg < 9) add_mixed();
            else add_noise();
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d requests: %0d full rejects, %0d range rejects, %0d locate hits.",
               accepted_count, full_count, range_count, locate_hits);
      $display("Sender idling swept over 0, 53 and 15 percent with drains between phases.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
